FILE: hw/rtl/triangle_edge_split_defines.svh
//------------------------------------------------------------------------------
// Triangle edge split assertion macros
// Shared concurrent assertion forms for the triangle edge split modules.
//------------------------------------------------------------------------------
`ifndef TRIANGLE_EDGE_SPLIT_DEFINES_SVH
`define TRIANGLE_EDGE_SPLIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tes assertion failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define TES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tes assertion failed: next-cycle rule");

`endif

FILE: hw/rtl/tes_pkg.sv
//------------------------------------------------------------------------------
// Triangle edge split package
// Shared item types, job record, split mode codes and constants.
//------------------------------------------------------------------------------
package tes_pkg;

   // Width of the vertex index fields on the ports.
   localparam int VERT_BITS = 32;
   // Significant index bits; indexes are taken modulo 2^INDEX_BITS.
   localparam int INDEX_BITS = 32;
   localparam int MASK_BITS = (INDEX_BITS < VERT_BITS) ? INDEX_BITS : VERT_BITS;
   localparam logic [VERT_BITS-1:0] VERT_MASK = {VERT_BITS{1'b1}} >> (VERT_BITS - MASK_BITS);

   // Jobs held between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [VERT_BITS-1:0] vert_type;

   typedef struct packed {
      vert_type corner_0;
      vert_type corner_1;
      vert_type corner_2;
      vert_type mid_01;
      vert_type mid_12;
      vert_type mid_20;
      logic     has_mid_01;
      logic     has_mid_12;
      logic     has_mid_20;
   } req_item_type;

   typedef struct packed {
      vert_type tri_vert_a;
      vert_type tri_vert_b;
      vert_type tri_vert_c;
      logic     replaces_original;
      logic     last_of_run;
   } rsp_item_type;

   // Encoding equals the index of the last triangle emitted for the mode.
   typedef enum logic [1:0] {
      SPLIT_NONE = 2'd0,
      SPLIT_ONE  = 2'd1,
      SPLIT_TWO  = 2'd2,
      SPLIT_ALL  = 2'd3
   } split_mode_type;

   // Edge rotation codes: which original edge lands on rotated edge 0.
   typedef enum logic [1:0] {
      ROT_EDGE_01 = 2'd0,
      ROT_EDGE_12 = 2'd1,
      ROT_EDGE_20 = 2'd2
   } rot_type;

   // Rotated triangle: corner k and mid k follow the original winding.
   typedef struct packed {
      vert_type       c0;
      vert_type       c1;
      vert_type       c2;
      vert_type       m0;
      vert_type       m1;
      vert_type       m2;
      split_mode_type mode;
   } job_type;

   function automatic logic [1:0] last_step(input split_mode_type mode);
      return logic'(1'b0) ? 2'd0 : mode;
   endfunction

endpackage

FILE: hw/rtl/tes_front.sv
//------------------------------------------------------------------------------
// Triangle edge split front
// Accepts triangles, counts split edges and rotates them into a job record.
//------------------------------------------------------------------------------
module tes_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  tes_pkg::req_item_type req_item,
   output logic                  q_push,
   input  logic                  q_full,
   output tes_pkg::job_type      q_job
);

   logic                  stage_valid_ff, stage_valid_in;
   tes_pkg::job_type      job_ff, job_in;
   logic                  take;
   logic [1:0]            n_split;
   tes_pkg::split_mode_type mode;
   tes_pkg::rot_type      rot;

   assign q_push   = stage_valid_ff && !q_full;
   assign req_full = stage_valid_ff && q_full;
   assign take     = req_push && !req_full;
   assign q_job    = job_ff;

   // Classify by number of split edges.
   always_comb begin
      n_split = 2'({1'b0, req_item.has_mid_01} + {1'b0, req_item.has_mid_12}
                   + {1'b0, req_item.has_mid_20});
      mode = tes_pkg::split_mode_type'(n_split);
      rot  = tes_pkg::ROT_EDGE_01;
      case (mode)
         tes_pkg::SPLIT_ONE: begin
            // rotate the single split edge to edge 0
            if (req_item.has_mid_01)      rot = tes_pkg::ROT_EDGE_01;
            else if (req_item.has_mid_12) rot = tes_pkg::ROT_EDGE_12;
            else                          rot = tes_pkg::ROT_EDGE_20;
         end
         tes_pkg::SPLIT_TWO: begin
            // rotate the unsplit edge to edge 0
            if (!req_item.has_mid_01)      rot = tes_pkg::ROT_EDGE_01;
            else if (!req_item.has_mid_12) rot = tes_pkg::ROT_EDGE_12;
            else                           rot = tes_pkg::ROT_EDGE_20;
         end
         default: rot = tes_pkg::ROT_EDGE_01;
      endcase
   end

   always_comb begin
      job_in.mode = mode;
      case (rot)
         tes_pkg::ROT_EDGE_12: begin
            job_in.c0 = req_item.corner_1;
            job_in.c1 = req_item.corner_2;
            job_in.c2 = req_item.corner_0;
            job_in.m0 = req_item.mid_12;
            job_in.m1 = req_item.mid_20;
            job_in.m2 = req_item.mid_01;
         end
         tes_pkg::ROT_EDGE_20: begin
            job_in.c0 = req_item.corner_2;
            job_in.c1 = req_item.corner_0;
            job_in.c2 = req_item.corner_1;
            job_in.m0 = req_item.mid_20;
            job_in.m1 = req_item.mid_01;
            job_in.m2 = req_item.mid_12;
         end
         default: begin
            job_in.c0 = req_item.corner_0;
            job_in.c1 = req_item.corner_1;
            job_in.c2 = req_item.corner_2;
            job_in.m0 = req_item.mid_01;
            job_in.m1 = req_item.mid_12;
            job_in.m2 = req_item.mid_20;
         end
      endcase
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (q_push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job_in;
      end
   end

endmodule

FILE: hw/rtl/tes_queue.sv
//------------------------------------------------------------------------------
// Triangle edge split job queue
// Short first-in first-out queue of jobs between the front and back parts.
//------------------------------------------------------------------------------
`include "triangle_edge_split_defines.svh"

module tes_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  tes_pkg::job_type push_job,
   input  logic             pop,
   output logic             empty,
   output tes_pkg::job_type pop_job
);

   tes_pkg::job_type                 entry_ff [tes_pkg::QUEUE_DEPTH];
   logic [tes_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tes_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tes_pkg::QCNT_BITS-1:0]    count_ff, count_in;
   logic                             do_push, do_pop;

   assign full    = (count_ff == tes_pkg::QCNT_BITS'(tes_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   function automatic logic [tes_pkg::QPTR_BITS-1:0] next_ptr(
         input logic [tes_pkg::QPTR_BITS-1:0] ptr);
      if (ptr == tes_pkg::QPTR_BITS'(tes_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `TES_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1,
      count_ff <= tes_pkg::QCNT_BITS'(tes_pkg::QUEUE_DEPTH))
   `TES_ASSERT_NOW(a_no_push_when_full, clock, reset, full, !push)
   `TES_ASSERT_NEXT(a_push_fills, clock, reset, do_push && !do_pop, !empty)

endmodule

FILE: hw/rtl/tes_back.sv
//------------------------------------------------------------------------------
// Triangle edge split back
// Steps through the triangles of each job into the result register.
//------------------------------------------------------------------------------
`include "triangle_edge_split_defines.svh"

module tes_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  tes_pkg::job_type      q_job,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output tes_pkg::rsp_item_type rsp_item
);

   logic                  out_valid_ff, out_valid_in;
   tes_pkg::rsp_item_type out_ff, out_in;
   logic [1:0]            step_ff, step_in;
   logic                  advance, is_last;
   tes_pkg::vert_type     va, vb, vc;

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;
   assign advance   = !q_empty && (!out_valid_ff || rsp_pop);
   assign is_last   = (step_ff == tes_pkg::last_step(q_job.mode));
   assign q_pop     = advance && is_last;

   // Triangle for the current step of the rotated job.
   always_comb begin
      va = q_job.c0;
      vb = q_job.c1;
      vc = q_job.c2;
      case (q_job.mode)
         tes_pkg::SPLIT_ONE: begin
            case (step_ff)
               2'd0:    begin va = q_job.c0; vb = q_job.m0; vc = q_job.c2; end
               default: begin va = q_job.m0; vb = q_job.c1; vc = q_job.c2; end
            endcase
         end
         tes_pkg::SPLIT_TWO: begin
            case (step_ff)
               2'd0:    begin va = q_job.c1; vb = q_job.m1; vc = q_job.c0; end
               2'd1:    begin va = q_job.m1; vb = q_job.c2; vc = q_job.m2; end
               default: begin va = q_job.m2; vb = q_job.c0; vc = q_job.m1; end
            endcase
         end
         tes_pkg::SPLIT_ALL: begin
            case (step_ff)
               2'd0:    begin va = q_job.c0; vb = q_job.m0; vc = q_job.m2; end
               2'd1:    begin va = q_job.m0; vb = q_job.c1; vc = q_job.m1; end
               2'd2:    begin va = q_job.m1; vb = q_job.c2; vc = q_job.m2; end
               default: begin va = q_job.m0; vb = q_job.m1; vc = q_job.m2; end
            endcase
         end
         default: begin
            va = q_job.c0;
            vb = q_job.c1;
            vc = q_job.c2;
         end
      endcase
   end

   always_comb begin
      out_in.tri_vert_a        = va & tes_pkg::VERT_MASK;
      out_in.tri_vert_b        = vb & tes_pkg::VERT_MASK;
      out_in.tri_vert_c        = vc & tes_pkg::VERT_MASK;
      out_in.replaces_original = (step_ff == 2'd0);
      out_in.last_of_run       = is_last;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      step_in      = step_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         step_in      = is_last ? 2'd0 : step_ff + 2'd1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   `TES_ASSERT_NOW(a_step_within_job, clock, reset, !q_empty,
      step_ff <= tes_pkg::last_step(q_job.mode))
   `TES_ASSERT_NOW(a_job_held_mid_run, clock, reset, step_ff != 2'd0, !q_empty)
   `TES_ASSERT_NEXT(a_pop_marks_last, clock, reset, q_pop,
      out_valid_ff && out_ff.last_of_run)

endmodule

FILE: hw/rtl/triangle_edge_split.sv
// A taken item passes the front stage, the job queue and the result register before its
// first triangle is on rsp_item. One triangle per cycle while the result side pops; an
// item yields 1 to 4 triangles, so a fully split face yields 4, all through the back part's single result register.
// Reset: synchronous, active high; clears the front stage, job queue and result valid.
// No clearing pass: the block takes items in the first cycle after reset.
//------------------------------------------------------------------------------
// Triangle edge split
// One red/green refinement step: replaces a triangle by its split triangles.
//------------------------------------------------------------------------------
module triangle_edge_split (
   input  logic                  clock,
   input  logic                  reset,
   // input items: one triangle with optional edge midpoints
   input  logic                  req_push,
   output logic                  req_full,
   input  tes_pkg::req_item_type req_item,
   // result items: one emitted triangle each
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output tes_pkg::rsp_item_type rsp_item
);

   // Front to queue: classified and rotated job.
   logic             fq_push;
   logic             fq_full;
   tes_pkg::job_type fq_job;

   // Queue to back: oldest job waiting for its triangles.
   logic             qb_empty;
   logic             qb_pop;
   tes_pkg::job_type qb_job;

   // Front: hold one item in its stage, count split edges and rotate the
   // triangle so the back part works from a fixed edge order. Advance the
   // stage into the queue whenever the queue has room.
   tes_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_push   (fq_push),
      .q_full   (fq_full),
      .q_job    (fq_job)
   );

   // Queue: decouple the front from the back so a stalled result side does
   // not stop the front from taking the next item until the queue is full.
   tes_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .full     (fq_full),
      .push_job (fq_job),
      .pop      (qb_pop),
      .empty    (qb_empty),
      .pop_job  (qb_job)
   );

   // Back: emit one triangle per cycle into the result register while it is free or
   // being popped; drop the job from the queue on its last triangle.
   tes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (qb_empty),
      .q_job     (qb_job),
      .q_pop     (qb_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: tb/sv/triangle_edge_split_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Triangle edge split checker
// Watches both item channels, works out the triangles each accepted face must
// turn into and compares every popped triangle against the oldest one waiting.
//------------------------------------------------------------------------------
module triangle_edge_split_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  tes_pkg::req_item_type req_item,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  tes_pkg::rsp_item_type rsp_item,
   output int unsigned           mismatch_count,
   output int unsigned           tris_checked,
   output int unsigned           tris_waiting
);
   import tes_pkg::*;

   rsp_item_type expected_tris[$];

   initial begin
      mismatch_count = 0;
      tris_checked = 0;
      tris_waiting = 0;
   end

   function automatic rsp_item_type make_tri(vert_type a, vert_type b, vert_type c,
                                             logic first);
      rsp_item_type t;
      t.tri_vert_a = a & VERT_MASK;
      t.tri_vert_b = b & VERT_MASK;
      t.tri_vert_c = c & VERT_MASK;
      t.replaces_original = first;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   // Queue up the replacement triangles of one face, in emission order.
   function automatic void split_face(req_item_type face);
      vert_type       cv [3];
      vert_type       mv [3];
      logic           sp [3];
      rsp_item_type   tris [4];
      split_mode_type mode;
      int             n, e, e1, e2, cnt;
      cv[0] = face.corner_0;
      cv[1] = face.corner_1;
      cv[2] = face.corner_2;
      mv[0] = face.mid_01;
      mv[1] = face.mid_12;
      mv[2] = face.mid_20;
      sp[0] = face.has_mid_01;
      sp[1] = face.has_mid_12;
      sp[2] = face.has_mid_20;
      n = 0;
      e = 0;
      for (int j = 0; j < 3; j++) begin
         if (sp[j]) n++;
      end
      mode = split_mode_type'(n);
      case (mode)
         SPLIT_NONE: begin
            tris[0] = make_tri(cv[0], cv[1], cv[2], 1'b1);
            cnt = 1;
         end
         SPLIT_ONE: begin
            // bisect the one split edge, keeping the opposite corner in both halves
            for (int j = 0; j < 3; j++) begin
               if (sp[j]) e = j;
            end
            tris[0] = make_tri(cv[e], mv[e], cv[(e + 2) % 3], 1'b1);
            tris[1] = make_tri(mv[e], cv[(e + 1) % 3], cv[(e + 2) % 3], 1'b0);
            cnt = 2;
         end
         SPLIT_TWO: begin
            // anchor the fan on the one unsplit edge
            for (int j = 0; j < 3; j++) begin
               if (!sp[j]) e = j;
            end
            e1 = (e + 1) % 3;
            e2 = (e + 2) % 3;
            tris[0] = make_tri(cv[e1], mv[e1], cv[e], 1'b1);
            tris[1] = make_tri(mv[e1], cv[e2], mv[e2], 1'b0);
            tris[2] = make_tri(mv[e2], cv[e], mv[e1], 1'b0);
            cnt = 3;
         end
         default: begin
            tris[0] = make_tri(cv[0], mv[0], mv[2], 1'b1);
            tris[1] = make_tri(mv[0], cv[1], mv[1], 1'b0);
            tris[2] = make_tri(mv[1], cv[2], mv[2], 1'b0);
            tris[3] = make_tri(mv[0], mv[1], mv[2], 1'b0);
            cnt = 4;
         end
      endcase
      tris[cnt - 1].last_of_run = 1'b1;
      for (int k = 0; k < cnt; k++) begin
         expected_tris = {expected_tris, tris[k]};
      end
   endfunction

   function automatic void check_field(string name, logic [VERT_BITS-1:0] want,
                                       logic [VERT_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_tri(rsp_item_type got);
      rsp_item_type want;
      if (expected_tris.size() == 0) begin
         $error("triangle popped with none expected: %0h %0h %0h",
                got.tri_vert_a, got.tri_vert_b, got.tri_vert_c);
         mismatch_count++;
      end else begin
         want = expected_tris.pop_front();
         check_field("tri_vert_a", want.tri_vert_a, got.tri_vert_a);
         check_field("tri_vert_b", want.tri_vert_b, got.tri_vert_b);
         check_field("tri_vert_c", want.tri_vert_c, got.tri_vert_c);
         check_field("replaces_original", VERT_BITS'(want.replaces_original),
                     VERT_BITS'(got.replaces_original));
         check_field("last_of_run", VERT_BITS'(want.last_of_run),
                     VERT_BITS'(got.last_of_run));
         tris_checked++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) split_face(req_item);
         if (rsp_pop && !rsp_empty) check_tri(rsp_item);
      end
      tris_waiting <= expected_tris.size();
   end

endmodule

FILE: tb/sv/triangle_edge_split_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Triangle edge split testbench
// Feeds faces with every split pattern, extreme and random vertex indices into
// the block, pops the triangles with random stalls and one long hold-off, and
// lets the checker compare each triangle with its predicted value.
//------------------------------------------------------------------------------
module triangle_edge_split_test;
   import tes_pkg::*;

   localparam int RANDOM_FACES = 280;
   localparam int HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT = 100000;

   logic         clock;
   logic         reset;
   logic         req_push;
   logic         req_full;
   req_item_type req_item;
   logic         rsp_empty;
   logic         rsp_pop;
   rsp_item_type rsp_item;

   int unsigned mismatch_count;
   int unsigned tris_checked;
   int unsigned tris_waiting;
   int unsigned cycle_count;
   int unsigned faces_sent;
   int unsigned split_mix [4];

   triangle_edge_split i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   triangle_edge_split_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_item       (req_item),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .tris_checked   (tris_checked),
      .tris_waiting   (tris_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Pick a vertex index: mostly full random, with zero, all ones and tiny values mixed in.
   function automatic vert_type pick_vert();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return vert_type'($urandom_range(15));
         default: return vert_type'($urandom);
      endcase
   endfunction

   function automatic req_item_type make_face(vert_type c0, vert_type c1, vert_type c2,
                                              vert_type m01, vert_type m12, vert_type m20,
                                              logic [2:0] splits);
      req_item_type f;
      f.corner_0 = c0;
      f.corner_1 = c1;
      f.corner_2 = c2;
      f.mid_01 = m01;
      f.mid_12 = m12;
      f.mid_20 = m20;
      f.has_mid_01 = splits[0];
      f.has_mid_12 = splits[1];
      f.has_mid_20 = splits[2];
      return f;
   endfunction

   // Offer one face and hold it until the block takes it. Idle cycles come
   // first, each one drawn at random; push is only lowered while idling.
   task automatic send_face(input req_item_type face, input bit may_idle);
      while (may_idle && ($urandom_range(99) < 27)) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_item <= face;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      faces_sent++;
      split_mix[int'(face.has_mid_01) + int'(face.has_mid_12) + int'(face.has_mid_20)]++;
   endtask

   // Result side: random stalls, a steady window, and one long hold-off once
   // traffic is flowing so the block backs up into its input.
   initial begin
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (!hold_done && faces_sent >= 60) begin
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
            rsp_pop <= 1'b0;
         end else if (faces_sent >= 150 && faces_sent < 250) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(99) >= 27);
         end
      end
   end

   // Stop a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d triangles still expected",
               cycle_count, tris_waiting);
      $display("FAIL triangle_edge_split");
      $finish;
   end

   initial begin
      req_item_type face;
      logic [2:0]   splits;
      faces_sent = 0;
      for (int k = 0; k < 4; k++) split_mix[k] = 0;
      reset = 1'b1;
      req_push = 1'b0;
      req_item = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Every split pattern with easy-to-read indices; midpoints of unsplit
      // edges carry junk that must be ignored.
      for (int s = 0; s < 8; s++) begin
         send_face(make_face(32'd10, 32'd20, 32'd30, 32'd101, 32'd112, 32'd120,
                             3'(s)), 1'b1);
      end
      // Extremes of the index range.
      send_face(make_face('0, '0, '0, '0, '0, '0, 3'b111), 1'b1);
      send_face(make_face('1, '1, '1, '1, '1, '1, 3'b111), 1'b1);
      send_face(make_face('1, '1, '1, '1, '1, '1, 3'b000), 1'b1);
      send_face(make_face('0, '1, '0, '1, '0, '1, 3'b111), 1'b1);
      send_face(make_face(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 3'b111), 1'b1);
      send_face(make_face(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 3'b101), 1'b1);
      send_face(make_face(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                          32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_FFFF, 3'b010), 1'b1);
      send_face(make_face('1, '0, '1, '0, '1, '0, 3'b000), 1'b1);

      // Random faces; a middle stretch goes back to back with no idle gaps.
      for (int n = 0; n < RANDOM_FACES; n++) begin
         splits = 3'($urandom_range(7));
         face = make_face(pick_vert(), pick_vert(), pick_vert(),
                          pick_vert(), pick_vert(), pick_vert(), splits);
         send_face(face, !(n >= 180 && n < 240));
      end
      req_push <= 1'b0;

      // Drain: the first wait lets the count catch up with the last accepted face.
      do @(posedge clock); while (tris_waiting != 0);
      repeat (10) @(posedge clock);

      $display("faces sent: %0d (unsplit %0d, one edge %0d, two edges %0d, all edges %0d)",
               faces_sent, split_mix[0], split_mix[1], split_mix[2], split_mix[3]);
      $display("triangles checked: %0d, incl. one %0d-cycle result hold-off; mismatches: %0d",
               tris_checked, HOLD_CYCLES, mismatch_count);
      if (mismatch_count == 0 && tris_waiting == 0) begin
         $display("PASS triangle_edge_split");
      end else begin
         $display("FAIL triangle_edge_split");
      end
      $finish;
   end

endmodule
